>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define ASSERT_NEXT(lbl, clk, rstn, pre, post, msg)
`endif

`endif

>>> rtl/core/psola_pkg.sv
// ----------------------------------------------------------------------------
// psola_pkg
// Shared types and constants of the pitch shifter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package psola_pkg;

    localparam int SAMPLE_W = 16;
    localparam int RESULT_W = 24;
    localparam int SR_W     = 15;
    localparam int PITCH_W  = 11;
    localparam int CFG_W    = 15;
    localparam int CFG_IDX_W = 2;

    localparam logic [PITCH_W-1:0] MIN_PITCH = 11'd100;
    localparam logic [15:0]        Q15_MAX   = 16'd32767;
    localparam int                 Q15_BITS  = 15;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_PITCH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DESIRED_PITCH = 2'd2;

    typedef enum logic [11:0] {
        S_CLEAR = 12'b0000_0000_0001,
        S_IDLE  = 12'b0000_0000_0010,
        S_OUT   = 12'b0000_0000_0100,
        S_DIVA  = 12'b0000_0000_1000,
        S_MUL   = 12'b0000_0001_0000,
        S_DIVB  = 12'b0000_0010_0000,
        S_DIVC  = 12'b0000_0100_0000,
        S_SEG   = 12'b0000_1000_0000,
        S_RD    = 12'b0001_0000_0000,
        S_MULT  = 12'b0010_0000_0000,
        S_WR    = 12'b0100_0000_0000,
        S_COPY  = 12'b1000_0000_0000
    } state_t;

endpackage

>>> rtl/core/psola_pitch_shifter.sv
// ----------------------------------------------------------------------------
// psola_pitch_shifter
// Block based TD-PSOLA pitch shifter on Q15 samples. Each input sample
// returns the sample at the same position of the previous block's result,
// so output lags input by one block. A sample request is accepted with the
// result-store read, then goes to the output register; the output register
// frees the next request once taken. After the last sample of a block the
// block stalls input for the processing pass: three shared restoring
// divisions and a multiply step (all but the first skipped for a zero
// shift), then per overlap-add term a read, a multiply and an accumulator
// write-back on a single-port-read RAM, then a copy of the accumulator into
// the result store while clearing it. After reset a clearing pass zeroes
// the accumulator and result store before the first sample is accepted.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module psola_pitch_shifter #(
    parameter int BLOCK_LEN = 512
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [psola_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [psola_pkg::CFG_W-1:0]        cfg_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [psola_pkg::SAMPLE_W-1:0]     s_axis_tdata,  // [15:0] sample_in
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [psola_pkg::RESULT_W-1:0]     m_axis_tdata   // [23:0] sample_out
);

    import psola_pkg::*;

    localparam int AW = $clog2(BLOCK_LEN);
    localparam int SW = ((AW > 10) ? AW : 10) + 2;
    localparam int CW = AW + 1;

    state_t state_reg, state_next;

    logic [AW-1:0]          pos_reg, pos_next;
    logic [RESULT_W-1:0]    out_data_reg, out_data_next;
    logic                   out_valid_reg, out_valid_next;
    logic [SR_W-1:0]        sr_reg;
    logic [PITCH_W-1:0]     ip_reg, dp_reg;

    logic [17:0]            div_num_reg, div_num_next;
    logic [11:0]            div_den_reg, div_den_next;
    logic [12:0]            div_rem_reg, div_rem_next;
    logic [4:0]             div_cnt_reg, div_cnt_next;

    logic [8:0]             shift_reg, shift_next;
    logic [9:0]             n_reg, n_next;
    logic [9:0]             synth_reg, synth_next;
    logic [16:0]            slope_reg, slope_next;

    logic signed [SW-1:0]   a_idx_reg, a_idx_next;
    logic [SW-1:0]          s_idx_reg, s_idx_next;
    logic [AW-1:0]          seg_start_reg, seg_start_next;
    logic [9:0]             seg_cnt_reg, seg_cnt_next;
    logic [9:0]             k_reg, k_next;
    logic [AW-1:0]          j_reg, j_next;
    logic [15:0]            tap_reg, tap_next;
    logic signed [32:0]     prod_reg, prod_next;
    logic [CW-1:0]          cnt_reg, cnt_next;

    // memories
    logic                   blk_we, blk_re;
    logic [AW-1:0]          blk_waddr, blk_raddr;
    logic [SAMPLE_W-1:0]    blk_wdata, blk_rdata;
    logic                   acc_we, acc_re;
    logic [AW-1:0]          acc_waddr, acc_raddr;
    logic [RESULT_W-1:0]    acc_wdata, acc_rdata;
    logic                   res_we, res_re;
    logic [AW-1:0]          res_waddr, res_raddr;
    logic [RESULT_W-1:0]    res_wdata, res_rdata;

    psola_ram #(.WIDTH(SAMPLE_W), .DEPTH(BLOCK_LEN)) u_blk_ram (
        .clk(clk), .we(blk_we), .waddr(blk_waddr), .wdata(blk_wdata),
        .re(blk_re), .raddr(blk_raddr), .rdata(blk_rdata)
    );

    psola_ram #(.WIDTH(RESULT_W), .DEPTH(BLOCK_LEN)) u_acc_ram (
        .clk(clk), .we(acc_we), .waddr(acc_waddr), .wdata(acc_wdata),
        .re(acc_re), .raddr(acc_raddr), .rdata(acc_rdata)
    );

    psola_ram #(.WIDTH(RESULT_W), .DEPTH(BLOCK_LEN)) u_res_ram (
        .clk(clk), .we(res_we), .waddr(res_waddr), .wdata(res_wdata),
        .re(res_re), .raddr(res_raddr), .rdata(res_rdata)
    );

    // clamped pitches
    logic [PITCH_W-1:0] ipc, dpc;
    assign ipc = (ip_reg < MIN_PITCH) ? MIN_PITCH : ip_reg;
    assign dpc = (dp_reg < MIN_PITCH) ? MIN_PITCH : dp_reg;

    // shared divider step
    logic [12:0] rem_sh, rem_new;
    logic        div_ge;
    logic [17:0] num_new;
    assign rem_sh  = {div_rem_reg[11:0], div_num_reg[17]};
    assign div_ge  = rem_sh >= {1'b0, div_den_reg};
    assign rem_new = div_ge ? (rem_sh - {1'b0, div_den_reg}) : rem_sh;
    assign num_new = {div_num_reg[16:0], div_ge};

    // segment bounds
    logic signed [SW-1:0] limit, a1, seg_start_c, seg_end_c;
    logic [SW-1:0]        j_c;
    assign limit = $signed(SW'(BLOCK_LEN)) - $signed(SW'(shift_reg)) - $signed(SW'(1));
    assign a1    = a_idx_reg + $signed(SW'(1)) - $signed(SW'(shift_reg[8:1]));
    always_comb
    begin
        seg_start_c = (a1 < 0) ? '0 : a1;
        seg_end_c   = seg_start_c + $signed(SW'(n_reg));
        if (seg_end_c > $signed(SW'(BLOCK_LEN - 1)))
        begin
            seg_end_c = $signed(SW'(BLOCK_LEN - 1));
        end
    end
    assign j_c = s_idx_reg + SW'(k_reg);

    // window tap, computed on the fly
    logic [9:0]  mid, kk;
    logic [26:0] tap_prod;
    logic [15:0] tap_c;
    assign mid      = n_reg >> 1;
    assign kk       = (k_reg <= mid) ? k_reg : (n_reg - k_reg);
    assign tap_prod = kk * slope_reg;
    assign tap_c    = ((k_reg == mid) && !n_reg[0]) ? Q15_MAX : tap_prod[15:0];

    // rounded Q15 term
    logic signed [33:0] rnd;
    logic signed [18:0] term;
    assign rnd  = 34'(prod_reg) + 34'sd16384;
    assign term = 19'(rnd >>> Q15_BITS);

    logic in_acc;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE) && !out_valid_reg;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg;
        div_num_next   = div_num_reg;
        div_den_next   = div_den_reg;
        div_rem_next   = div_rem_reg;
        div_cnt_next   = div_cnt_reg;
        shift_next     = shift_reg;
        n_next         = n_reg;
        synth_next     = synth_reg;
        slope_next     = slope_reg;
        a_idx_next     = a_idx_reg;
        s_idx_next     = s_idx_reg;
        seg_start_next = seg_start_reg;
        seg_cnt_next   = seg_cnt_reg;
        k_next         = k_reg;
        j_next         = j_reg;
        tap_next       = tap_reg;
        prod_next      = prod_reg;
        cnt_next       = cnt_reg;

        blk_we = 1'b0; blk_waddr = pos_reg; blk_wdata = s_axis_tdata;
        blk_re = 1'b0; blk_raddr = AW'(seg_start_reg + AW'(k_reg));
        acc_we = 1'b0; acc_waddr = j_reg; acc_wdata = '0;
        acc_re = 1'b0; acc_raddr = j_c[AW-1:0];
        res_we = 1'b0; res_waddr = cnt_reg[AW-1:0]; res_wdata = '0;
        res_re = 1'b0; res_raddr = pos_reg;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                acc_we    = 1'b1;
                acc_waddr = cnt_reg[AW-1:0];
                res_we    = 1'b1;
                if (cnt_reg == CW'(BLOCK_LEN - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (in_acc)
                begin
                    blk_we     = 1'b1;
                    res_re     = 1'b1;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                out_data_next  = res_rdata;
                out_valid_next = 1'b1;
                if (pos_reg == AW'(BLOCK_LEN - 1))
                begin
                    pos_next     = '0;
                    div_num_next = 18'(sr_reg) + 18'(ipc) - 18'd1;
                    div_den_next = 12'(ipc);
                    div_rem_next = '0;
                    div_cnt_next = '0;
                    state_next   = S_DIVA;
                end
                else
                begin
                    pos_next   = pos_reg + 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_DIVA, S_DIVB, S_DIVC:
            begin
                div_num_next = num_new;
                div_rem_next = rem_new;
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == 5'd17)
                begin
                    if (state_reg == S_DIVA)
                    begin
                        shift_next = num_new[8:0];
                        cnt_next   = '0;
                        state_next = (num_new == '0) ? S_COPY : S_MUL;
                    end
                    else if (state_reg == S_DIVB)
                    begin
                        synth_next   = num_new[9:0];
                        div_num_next = 18'd131072 + 18'(n_reg);
                        div_den_next = 12'({n_reg, 1'b0});
                        div_rem_next = '0;
                        div_cnt_next = '0;
                        state_next   = S_DIVC;
                    end
                    else
                    begin
                        slope_next = num_new[16:0];
                        a_idx_next = -$signed(SW'(1));
                        s_idx_next = '0;
                        state_next = S_SEG;
                    end
                end
            end
            S_MUL:
            begin
                div_num_next = 18'({20'(shift_reg * ipc), 1'b0} + 21'(dpc));
                div_den_next = 12'({dpc, 1'b0});
                div_rem_next = '0;
                div_cnt_next = '0;
                n_next       = 10'(shift_reg) + 10'(shift_reg[8:1]);
                state_next   = S_DIVB;
            end
            S_SEG:
            begin
                if (!(a_idx_reg < limit))
                begin
                    cnt_next   = '0;
                    state_next = S_COPY;
                end
                else if (s_idx_reg >= SW'(BLOCK_LEN))
                begin
                    // result positions already past the block
                    a_idx_next = a_idx_reg + $signed(SW'(shift_reg));
                end
                else
                begin
                    seg_start_next = seg_start_c[AW-1:0];
                    seg_cnt_next   = 10'(seg_end_c - seg_start_c);
                    k_next         = '0;
                    state_next     = S_RD;
                end
            end
            S_RD:
            begin
                if (j_c >= SW'(BLOCK_LEN))
                begin
                    a_idx_next = a_idx_reg + $signed(SW'(shift_reg));
                    s_idx_next = s_idx_reg + SW'(synth_reg);
                    state_next = S_SEG;
                end
                else
                begin
                    blk_re     = 1'b1;
                    acc_re     = 1'b1;
                    j_next     = j_c[AW-1:0];
                    tap_next   = tap_c;
                    state_next = S_MULT;
                end
            end
            S_MULT:
            begin
                prod_next  = $signed(blk_rdata) * $signed({1'b0, tap_reg});
                state_next = S_WR;
            end
            S_WR:
            begin
                acc_we    = 1'b1;
                acc_wdata = acc_rdata + RESULT_W'(term);
                if (k_reg == seg_cnt_reg)
                begin
                    a_idx_next = a_idx_reg + $signed(SW'(shift_reg));
                    s_idx_next = s_idx_reg + SW'(synth_reg);
                    state_next = S_SEG;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_RD;
                end
            end
            S_COPY:
            begin
                // read entry i while writing back entry i-1
                acc_raddr = cnt_reg[AW-1:0];
                acc_re    = (cnt_reg != CW'(BLOCK_LEN));
                if (cnt_reg != '0)
                begin
                    res_we    = 1'b1;
                    res_waddr = AW'(cnt_reg - 1'b1);
                    res_wdata = acc_rdata;
                    acc_we    = 1'b1;
                    acc_waddr = AW'(cnt_reg - 1'b1);
                end
                if (cnt_reg == CW'(BLOCK_LEN))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            sr_reg        <= 15'd8000;
            ip_reg        <= 11'd100;
            dp_reg        <= 11'd100;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SAMPLE_RATE:   sr_reg <= cfg_data[SR_W-1:0];
                    CFG_INPUT_PITCH:   ip_reg <= cfg_data[PITCH_W-1:0];
                    CFG_DESIRED_PITCH: dp_reg <= cfg_data[PITCH_W-1:0];
                    default:           ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        div_num_reg   <= div_num_next;
        div_den_reg   <= div_den_next;
        div_rem_reg   <= div_rem_next;
        div_cnt_reg   <= div_cnt_next;
        shift_reg     <= shift_next;
        n_reg         <= n_next;
        synth_reg     <= synth_next;
        slope_reg     <= slope_next;
        a_idx_reg     <= a_idx_next;
        s_idx_reg     <= s_idx_next;
        seg_start_reg <= seg_start_next;
        seg_cnt_reg   <= seg_cnt_next;
        k_reg         <= k_next;
        j_reg         <= j_next;
        tap_reg       <= tap_next;
        prod_reg      <= prod_next;
    end

    `ASSERT_NEXT(a_req_to_out, clk, rst_n, in_acc, state_reg == S_OUT, "accepted sample did not reach output stage")
    `ASSERT_NEXT(a_out_valid, clk, rst_n, state_reg == S_OUT, out_valid_reg, "result not presented after read")
    `ASSERT_CLK(a_ready_idle, clk, rst_n, !s_axis_tready || (state_reg == S_IDLE), "ready outside idle")

endmodule

>>> rtl/core/psola_ram.sv
// ----------------------------------------------------------------------------
// psola_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module psola_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Pitch shifter check. Whole blocks and a partial one are streamed through
// under several rate and pitch settings. Each returned sample is compared with
// the in-bench overlap-add predictor or a directed result; output lags one block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    import psola_pkg::*;

    localparam int BLOCK    = 512;
    localparam int WIN_LEN  = 512;
    localparam int IDLE_MAX = 40000;
    localparam int SETTLE   = 6000;
    localparam int TAIL_LEN = 280;

    typedef struct {
        logic [SAMPLE_W-1:0] sample;
        logic [RESULT_W-1:0] result;
    } stim_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [SAMPLE_W-1:0]  s_axis_tdata;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [RESULT_W-1:0]  m_axis_tdata;

    // predictor state
    logic [SR_W-1:0]     rate_reg;
    logic [PITCH_W-1:0]  in_pitch_reg;
    logic [PITCH_W-1:0]  out_pitch_reg;
    logic signed [15:0]  blk_samples [BLOCK];
    logic [RESULT_W-1:0] ola_sum [BLOCK];
    logic [RESULT_W-1:0] prev_block [BLOCK];
    logic [15:0]         taps [WIN_LEN];
    int                  blk_pos;

    logic [RESULT_W-1:0] expected_samples [$];
    logic [RESULT_W+1:0] typed_results [$];   // {known, pad, value}
    int  n_errors;
    int  n_in;
    int  n_out;
    int  n_blocks;
    int  idle_cycles;
    int  burst_left;

    psola_pitch_shifter #(.BLOCK_LEN(BLOCK)) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void shift_block();
        int ip;
        int dp;
        int shift;
        int half;
        int synth;
        int n;
        int slope;
        int lim;
        int a_idx;
        int s_idx;
        int start;
        int stop;
        int j;
        longint t;
        ip = (in_pitch_reg < MIN_PITCH) ? int'(MIN_PITCH) : int'(in_pitch_reg);
        dp = (out_pitch_reg < MIN_PITCH) ? int'(MIN_PITCH) : int'(out_pitch_reg);
        shift = (int'(rate_reg) + ip - 1) / ip;
        if (shift > 0)
        begin
            half  = shift / 2;
            synth = (2 * shift * ip + dp) / (2 * dp);
            n     = shift + half;
            slope = (131072 + n) / (2 * n);
            for (int i = 0; i <= n && i < WIN_LEN; i++)
                taps[i] = 16'(((i <= n / 2) ? i : n - i) * slope);
            if (n % 2 == 0 && n / 2 < WIN_LEN)
                taps[n / 2] = Q15_MAX;
            lim   = BLOCK - shift - 1;
            a_idx = -1;
            s_idx = 0;
            while (a_idx < lim)
            begin
                start = a_idx + 1 - half;
                if (start < 0)
                    start = 0;
                stop = start + n;
                if (stop > BLOCK - 1)
                    stop = BLOCK - 1;
                for (int k = 0; k <= stop - start; k++)
                begin
                    j = s_idx + k;
                    if (j >= BLOCK)
                        break;
                    // rounded Q15 product, floor of the biased value
                    t = longint'(blk_samples[start + k]) * longint'({1'b0, taps[k % WIN_LEN]})
                        + 16384;
                    ola_sum[j] = ola_sum[j] + RESULT_W'(t >>> Q15_BITS);
                end
                a_idx += shift;
                s_idx += synth;
            end
        end
        for (int i = 0; i < BLOCK; i++)
        begin
            prev_block[i] = ola_sum[i];
            ola_sum[i]    = '0;
        end
    endfunction

    function automatic logic [RESULT_W-1:0] next_output(logic [SAMPLE_W-1:0] smp);
        logic [RESULT_W-1:0] r;
        r = prev_block[blk_pos];
        blk_samples[blk_pos] = smp;
        if (blk_pos == BLOCK - 1)
        begin
            shift_block();
            blk_pos = 0;
        end
        else
            blk_pos++;
        return r;
    endfunction

    // scoreboard and watchdog
    always @(posedge clk)
    begin
        logic [RESULT_W-1:0] exp_v;
        logic [RESULT_W+1:0] typed;
        if (rst_n)
        begin
            idle_cycles++;
            if (m_axis_tvalid && m_axis_tready)
            begin
                idle_cycles = 0;
                n_out++;
                if (expected_samples.size() == 0)
                begin
                    $error("unexpected sample_out %0d", $signed(m_axis_tdata));
                    n_errors++;
                end
                else
                begin
                    exp_v = expected_samples.pop_front();
                    if (m_axis_tdata !== exp_v)
                    begin
                        $error("sample_out: expected %0d, got %0d", $signed(exp_v),
                               $signed(m_axis_tdata));
                        n_errors++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                idle_cycles = 0;
                n_in++;
                exp_v = next_output(s_axis_tdata);
                typed = typed_results.pop_front();
                expected_samples.push_back(typed[RESULT_W+1] ? typed[RESULT_W-1:0] : exp_v);
            end
            if (idle_cycles >= IDLE_MAX)
            begin
                $display("watchdog: no request moved for %0d cycles", IDLE_MAX);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // receiver stall pattern: a random mode is redrawn periodically
    initial
    begin
        int mode;
        m_axis_tready = 1'b0;
        forever
        begin
            mode = $urandom_range(0, 3);
            for (int c = 0; c < 64; c++)
            begin
                @(negedge clk);
                case (mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= ($urandom_range(0, 1) == 1);
                    2: m_axis_tready <= ($urandom_range(0, 7) != 0);
                    default: m_axis_tready <= (c % 24 >= 18);
                endcase
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_SAMPLE_RATE:   rate_reg      = val[SR_W-1:0];
            CFG_INPUT_PITCH:   in_pitch_reg  = val[PITCH_W-1:0];
            CFG_DESIRED_PITCH: out_pitch_reg = val[PITCH_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic push_sample(logic [SAMPLE_W-1:0] smp, bit known, logic [RESULT_W-1:0] res);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) != 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge clk);
            end
        end
        burst_left--;
        typed_results.push_back({known, 1'b0, res});
        s_axis_tdata  <= smp;
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        wait (expected_samples.size() == 0);
        // block pass may still be running after the last output
        repeat (SETTLE) @(negedge clk);
    endtask

    function automatic logic [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(0, 9))
            0: return 16'h7FFF;
            1: return 16'h8000;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic run_block(int first);
        for (int i = first; i < BLOCK; i++)
            push_sample(rand_sample(), 1'b0, '0);
        n_blocks++;
    endtask

    stim_row_t directed [] = '{
        '{16'h0000, 24'd0}, '{16'h7FFF, 24'd0}, '{16'h8000, 24'd0},
        '{16'h0001, 24'd0}, '{16'hFFFF, 24'd0}, '{16'h5555, 24'd0},
        '{16'hAAAA, 24'd0}, '{16'h7FFE, 24'd0}, '{16'h8001, 24'd0},
        '{16'h4000, 24'd0}, '{16'hC000, 24'd0}, '{16'h00FF, 24'd0},
        '{16'hFF00, 24'd0}, '{16'h0F0F, 24'd0}, '{16'hF0F0, 24'd0},
        '{16'h7FFF, 24'd0}, '{16'h7FFF, 24'd0}, '{16'h8000, 24'd0},
        '{16'h8000, 24'd0}, '{16'h1234, 24'd0}
    };

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_SAMPLE_RATE;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        rate_reg      = SR_W'(8000);
        in_pitch_reg  = PITCH_W'(100);
        out_pitch_reg = PITCH_W'(100);
        foreach (blk_samples[i]) blk_samples[i] = '0;
        foreach (ola_sum[i]) ola_sum[i] = '0;
        foreach (prev_block[i]) prev_block[i] = '0;
        foreach (taps[i]) taps[i] = '0;
        blk_pos     = 0;
        n_errors    = 0;
        n_in        = 0;
        n_out       = 0;
        n_blocks    = 0;
        idle_cycles = 0;
        burst_left  = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // first block at reset settings: outputs are all zero
        foreach (directed[r])
            push_sample(directed[r].sample, 1'b1, directed[r].result);
        run_block(directed.size());

        // widest window at the fastest rate, pitch raised; input pitch below the floor
        drain();
        write_reg(CFG_SAMPLE_RATE, 15'd32767);
        write_reg(CFG_INPUT_PITCH, 15'd40);
        write_reg(CFG_DESIRED_PITCH, 15'd2047);
        run_block(0);

        // shortest shift, target pitch below the floor
        drain();
        write_reg(CFG_SAMPLE_RATE, 15'd1);
        write_reg(CFG_INPUT_PITCH, 15'd2000);
        write_reg(CFG_DESIRED_PITCH, 15'd0);
        run_block(0);

        // partial block to read back the last result
        drain();
        for (int i = 0; i < TAIL_LEN; i++)
            push_sample(rand_sample(), 1'b0, '0);
        drain();

        $display("covered %0d samples in %0d full blocks plus a partial one", n_in, n_blocks);
        $display("settings: reset, widest window with pitch floor, shortest shift");
        if (n_errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/psola_pkg.sv
rtl/core/psola_ram.sv
rtl/core/psola_pitch_shifter.sv
verif/testbench.sv
